// ===== sv/i2c_seq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the I2C EEPROM transfer sequencer.
// No dependencies; the top level, step logic and testbench import it.
package i2c_seq_pkg;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_START_READ  = 2'd0,
        CMD_START_WRITE = 2'd1,
        CMD_LOAD_BYTE   = 2'd2,
        CMD_BUS_EVENT   = 2'd3
    } t_cmd;

    // Bus actions requested from the I2C controller.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_WADDR = 3'd2,
        ACT_RADDR = 3'd3,
        ACT_BYTE  = 3'd4
    } t_bus_action;

    // Completion status of a command.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_BUSY     = 2'd2
    } t_status;

    // Transfer sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_R_START   = 4'd1,
        PH_R_WADDR   = 4'd2,
        PH_R_ADDR_HI = 4'd3,
        PH_R_ADDR_LO = 4'd4,
        PH_R_RESTART = 4'd5,
        PH_R_RADDR   = 4'd6,
        PH_R_DATA    = 4'd7,
        PH_W_START   = 4'd8,
        PH_W_WADDR   = 4'd9,
        PH_W_ADDR_LO = 4'd10,
        PH_W_DATA    = 4'd11,
        PH_W_LAST    = 4'd12
    } t_phase;

    // Bus controller status flags carried by a status event.
    typedef struct packed {
        logic start_sent;
        logic address_done;
        logic tx_empty;
        logic rx_full;
        logic byte_finished;
        logic ack_failure;
    } t_flags;

    // State updates requested by the step logic besides the phase.
    typedef struct packed {
        logic load_start;
        logic inc_index;
    } t_ctrl;

    // One result beat.
    typedef struct packed {
        t_bus_action bus_action;
        logic [7:0]  tx_byte;
        logic        clear_ack_failure;
        logic        ack_disable;
        logic        stop;
        logic        rx_valid;
        logic [7:0]  rx_data;
        logic        rx_last;
        logic        done_res;
        t_status     status;
    } t_result;

    // High memory address byte keeps five bits.
    localparam logic [4:0] ADDR_HI_MASK = 5'h1F;

endpackage

// ===== sv/i2c_eeprom_transfer_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the I2C EEPROM transfer sequencer: state registers, page buffer, output skid.
// Depends on i2c_seq_pkg, i2c_seq_step and i2c_seq_ram.
//
// This block sequences one random-access read or one write to an I2C EEPROM that
// uses a two-byte memory address. Each input beat is a command (start read, start
// write, load a page buffer byte) or a bus status event from the I2C controller,
// and each input beat yields exactly one result beat that tells the controller
// what to do next (start, address byte, data byte, stop, acknowledge control) and
// carries any received memory byte. Every beat is handled as it is accepted: the
// step logic reads the current phase and counters, updates them at the accepting
// edge and writes the result into an output register, so a new beat can be taken
// on every clock. A two-entry output stage (output register plus skid register)
// keeps accepting while a result waits downstream; the input stalls only when
// both entries are full. The page buffer is a RAM with a registered read port;
// its read address always follows the next buffer slot, so the byte for the next
// write data beat is ready ahead of it, and a load that hits that slot in the
// same cycle is forwarded. A start beyond the memory size, or a write of zero
// bytes, is rejected with a range status; a start while a transfer runs is
// rejected as busy. Load commands are taken at any time. The device address
// register is written through its own valid/ready port, which is always ready,
// and must only be changed while no transfer is in progress.
module i2c_eeprom_transfer_sequencer #(
    parameter int MEM_BYTES  = 8192,
    parameter int PAGE_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [12:0] i_mem_address,
    input  logic [13:0] i_length,
    input  logic [4:0]  i_buffer_index,
    input  logic [7:0]  i_data_byte,
    input  logic        i_flag_start_sent,
    input  logic        i_flag_address_done,
    input  logic        i_flag_tx_empty,
    input  logic        i_flag_rx_full,
    input  logic        i_flag_byte_finished,
    input  logic        i_flag_ack_failure,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_bus_action,
    output logic [7:0]  o_tx_byte,
    output logic        o_clear_ack_failure,
    output logic        o_ack_disable,
    output logic        o_stop,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_data,
    output logic        o_rx_last,
    output logic        o_done_res,
    output logic [1:0]  o_status
);
    import i2c_seq_pkg::*;

    localparam int             SLOT_W    = $clog2(PAGE_BYTES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PAGE_BYTES - 1);

    // Architectural state.
    logic [6:0]        r_device_address;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [13:0]       r_byte_index;
    logic [13:0]       n_byte_index;
    logic [13:0]       r_byte_count;
    logic [12:0]       r_target_address;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;

    // Page buffer forwarding.
    logic              r_byp_hit;
    logic [7:0]        r_byp_data;
    logic [7:0]        ram_rdata;
    logic [7:0]        buf_byte;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [8:0]        load_slot;

    // Output stage.
    t_result           r_out;
    logic              r_out_valid;
    t_result           r_skid;
    logic              r_skid_valid;

    logic              in_accept;
    logic              out_take;
    t_flags            flags;
    t_ctrl             ctrl;
    t_result           result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;

    assign flags.start_sent    = i_flag_start_sent;
    assign flags.address_done  = i_flag_address_done;
    assign flags.tx_empty      = i_flag_tx_empty;
    assign flags.rx_full       = i_flag_rx_full;
    assign flags.byte_finished = i_flag_byte_finished;
    assign flags.ack_failure   = i_flag_ack_failure;

    i2c_seq_step #(
        .MEM_BYTES (MEM_BYTES)
    ) u_step (
        .i_cmd            (i_cmd),
        .i_mem_address    (i_mem_address),
        .i_length         (i_length),
        .i_data_byte      (i_data_byte),
        .i_flags          (flags),
        .i_phase          (r_phase),
        .i_byte_index     (r_byte_index),
        .i_byte_count     (r_byte_count),
        .i_target_address (r_target_address),
        .i_device_address (r_device_address),
        .i_buf_byte       (buf_byte),
        .o_next_phase     (n_phase),
        .o_ctrl           (ctrl),
        .o_result         (result)
    );

    // Load slots wrap around the page buffer. The slot field is at most four
    // page sizes wide, so a few conditional subtractions reduce it.
    always_comb begin
        load_slot = {4'b0, i_buffer_index};
        for (int k = 0; k < 4; k++) begin
            if (load_slot >= 9'(PAGE_BYTES)) begin
                load_slot = load_slot - 9'(PAGE_BYTES);
            end
        end
    end

    assign ram_we    = in_accept && (t_cmd'(i_cmd) == CMD_LOAD_BYTE);
    assign ram_waddr = load_slot[SLOT_W-1:0];

    // The buffer slot tracks the byte index modulo the page size.
    always_comb begin
        n_byte_index = r_byte_index;
        n_slot       = r_slot;
        if (in_accept && ctrl.load_start) begin
            n_byte_index = '0;
            n_slot       = '0;
        end else if (in_accept && ctrl.inc_index) begin
            n_byte_index = r_byte_index + 14'd1;
            n_slot       = (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
        end
    end

    // The read port looks at the next slot, so its data is ready for the next beat.
    i2c_seq_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_page_buffer (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_byte),
        .i_raddr (n_slot),
        .o_rdata (ram_rdata)
    );

    assign buf_byte = r_byp_hit ? r_byp_data : ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= 7'd80;
            r_phase          <= PH_IDLE;
            r_byte_index     <= '0;
            r_byte_count     <= '0;
            r_target_address <= '0;
            r_slot           <= '0;
            r_byp_hit        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_device_address <= i_cfg_data;
            end
            if (in_accept) begin
                r_phase <= n_phase;
            end
            if (in_accept && ctrl.load_start) begin
                r_byte_count     <= i_length;
                r_target_address <= i_mem_address;
            end
            r_byte_index <= n_byte_index;
            r_slot       <= n_slot;
            // A load into the slot being read this cycle is not yet seen by the
            // RAM output, so forward it for one cycle.
            r_byp_hit    <= ram_we && (ram_waddr == n_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_data_byte;
    end

    // Output register plus skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_bus_action        = r_out.bus_action;
    assign o_tx_byte           = r_out.tx_byte;
    assign o_clear_ack_failure = r_out.clear_ack_failure;
    assign o_ack_disable       = r_out.ack_disable;
    assign o_stop              = r_out.stop;
    assign o_rx_valid          = r_out.rx_valid;
    assign o_rx_data           = r_out.rx_data;
    assign o_rx_last           = r_out.rx_last;
    assign o_done_res          = r_out.done_res;
    assign o_status            = r_out.status;

    // The skid entry only fills behind a held output entry.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    // A completed transfer always leaves the sequencer idle.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && result.done_res) |=> (r_phase == PH_IDLE))
        else $error("transfer done but phase not idle");

    // A busy rejection only happens while a transfer is running.
    a_busy_only_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (result.status == ST_BUSY)) |-> (r_phase != PH_IDLE))
        else $error("busy status reported while idle");

    // While sending write data the byte index never passes the byte count.
    a_write_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_W_DATA) |-> (r_byte_index <= r_byte_count))
        else $error("write byte index beyond byte count");

endmodule

// ===== sv/i2c_seq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the page buffer of the transfer sequencer.
module i2c_seq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/i2c_seq_step.sv =====
`timescale 1ns / 1ps
// Combinational step of the transfer sequencer: next phase, state updates and result.
// Depends on i2c_seq_pkg.
module i2c_seq_step #(
    parameter int MEM_BYTES = 8192
) (
    input  logic [1:0]           i_cmd,
    input  logic [12:0]          i_mem_address,
    input  logic [13:0]          i_length,
    input  logic [7:0]           i_data_byte,
    input  i2c_seq_pkg::t_flags  i_flags,
    input  i2c_seq_pkg::t_phase  i_phase,
    input  logic [13:0]          i_byte_index,
    input  logic [13:0]          i_byte_count,
    input  logic [12:0]          i_target_address,
    input  logic [6:0]           i_device_address,
    input  logic [7:0]           i_buf_byte,
    output i2c_seq_pkg::t_phase  o_next_phase,
    output i2c_seq_pkg::t_ctrl   o_ctrl,
    output i2c_seq_pkg::t_result o_result
);
    import i2c_seq_pkg::*;

    t_cmd        cmd;
    logic        is_start;
    logic        range_bad;
    logic        start_ok;
    logic        is_event;
    logic        more_rd;
    logic        more_wr;
    logic [16:0] end_address;
    logic [7:0]  waddr_byte;
    logic [7:0]  raddr_byte;
    logic [7:0]  addr_hi_byte;

    assign cmd          = t_cmd'(i_cmd);
    assign is_start     = (cmd == CMD_START_READ) || (cmd == CMD_START_WRITE);
    assign is_event     = (cmd == CMD_BUS_EVENT);
    assign end_address  = {4'b0, i_mem_address} + {3'b0, i_length};
    assign range_bad    = (end_address > 17'(MEM_BYTES))
                          || ((cmd == CMD_START_WRITE) && (i_length == 14'd0));
    assign start_ok     = is_start && (i_phase == PH_IDLE) && !range_bad;
    assign more_rd      = ({1'b0, i_byte_index} + 15'd1) < {1'b0, i_byte_count};
    assign more_wr      = i_byte_index < i_byte_count;
    assign waddr_byte   = {i_device_address, 1'b0};
    assign raddr_byte   = {i_device_address, 1'b1};
    assign addr_hi_byte = {3'b0, i_target_address[12:8] & ADDR_HI_MASK};

    // Next phase.
    always_comb begin
        o_next_phase = i_phase;
        if (start_ok) begin
            o_next_phase = (cmd == CMD_START_READ) ? PH_R_START : PH_W_START;
        end else if (is_event) begin
            unique case (i_phase)
                PH_R_START:   if (i_flags.start_sent)   o_next_phase = PH_R_WADDR;
                PH_R_WADDR:   if (i_flags.address_done) o_next_phase = PH_R_ADDR_HI;
                PH_R_ADDR_HI: if (i_flags.tx_empty)     o_next_phase = PH_R_ADDR_LO;
                PH_R_ADDR_LO: if (i_flags.tx_empty)     o_next_phase = PH_R_RESTART;
                PH_R_RESTART: if (i_flags.start_sent)   o_next_phase = PH_R_RADDR;
                PH_R_RADDR:   if (i_flags.address_done) o_next_phase = PH_R_DATA;
                PH_R_DATA:    if (i_flags.rx_full && !more_rd) o_next_phase = PH_IDLE;
                PH_W_START:   if (i_flags.start_sent)   o_next_phase = PH_W_WADDR;
                PH_W_WADDR: begin
                    if (i_flags.ack_failure) begin
                        o_next_phase = PH_W_START;
                    end else if (i_flags.address_done) begin
                        o_next_phase = PH_W_ADDR_LO;
                    end
                end
                PH_W_ADDR_LO: if (i_flags.tx_empty)     o_next_phase = PH_W_DATA;
                PH_W_DATA:    if (i_flags.tx_empty && !more_wr) o_next_phase = PH_W_LAST;
                PH_W_LAST:    if (i_flags.byte_finished) o_next_phase = PH_IDLE;
                default:      o_next_phase = i_phase;
            endcase
        end
    end

    // Result beat and counter updates.
    always_comb begin
        o_result          = '0;
        o_ctrl            = '0;
        o_ctrl.load_start = start_ok;
        if (is_start) begin
            if (i_phase != PH_IDLE) begin
                o_result.status = ST_BUSY;
            end else if (range_bad) begin
                o_result.status = ST_RANGE;
            end else begin
                o_result.bus_action = ACT_START;
            end
        end else if (is_event) begin
            unique case (i_phase)
                PH_R_START, PH_W_START: begin
                    if (i_flags.start_sent) begin
                        o_result.bus_action = ACT_WADDR;
                        o_result.tx_byte    = waddr_byte;
                    end
                end
                PH_R_WADDR: begin
                    if (i_flags.address_done) begin
                        o_result.bus_action = ACT_BYTE;
                        o_result.tx_byte    = addr_hi_byte;
                    end
                end
                PH_R_ADDR_HI, PH_W_ADDR_LO: begin
                    if (i_flags.tx_empty) begin
                        o_result.bus_action = ACT_BYTE;
                        o_result.tx_byte    = i_target_address[7:0];
                    end
                end
                PH_R_ADDR_LO: begin
                    if (i_flags.tx_empty) begin
                        o_result.bus_action = ACT_START;
                    end
                end
                PH_R_RESTART: begin
                    if (i_flags.start_sent) begin
                        o_result.bus_action = ACT_RADDR;
                        o_result.tx_byte    = raddr_byte;
                    end
                end
                PH_R_DATA: begin
                    if (i_flags.rx_full) begin
                        o_ctrl.inc_index = 1'b1;
                        o_result.rx_valid = 1'b1;
                        o_result.rx_data  = i_data_byte;
                        if (!more_rd) begin
                            o_result.ack_disable = 1'b1;
                            o_result.stop        = 1'b1;
                            o_result.rx_last     = 1'b1;
                            o_result.done_res    = 1'b1;
                        end
                    end
                end
                PH_W_WADDR: begin
                    if (i_flags.ack_failure) begin
                        // Device still busy with its internal write: poll again.
                        o_result.clear_ack_failure = 1'b1;
                        o_result.bus_action        = ACT_START;
                    end else if (i_flags.address_done) begin
                        o_result.bus_action = ACT_BYTE;
                        o_result.tx_byte    = addr_hi_byte;
                    end
                end
                PH_W_DATA: begin
                    if (i_flags.tx_empty && more_wr) begin
                        o_ctrl.inc_index    = 1'b1;
                        o_result.bus_action = ACT_BYTE;
                        o_result.tx_byte    = i_buf_byte;
                    end
                end
                PH_W_LAST: begin
                    if (i_flags.byte_finished) begin
                        o_result.stop     = 1'b1;
                        o_result.done_res = 1'b1;
                    end
                end
                default: begin
                    o_result = '0;
                end
            endcase
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for i2c_eeprom_transfer_sequencer: directed and random beats.
// Depends on i2c_seq_pkg and the sequencer RTL; needs no other file.
module tb_top;
    import i2c_seq_pkg::*;

    localparam int MEM_BYTES    = 8192;
    localparam int PAGE_BYTES   = 32;
    // Cycles without any beat on any channel before the run is declared hung.
    localparam int HANG_LIMIT   = 2000;
    // Extra cycles to wait after the last result has been seen.
    localparam int DRAIN_CYCLES = 4;

    // One input beat as the generator builds it.
    typedef struct packed {
        t_cmd        cmd;
        logic [12:0] mem_address;
        logic [13:0] length;
        logic [4:0]  buffer_index;
        logic [7:0]  data_byte;
        t_flags      flags;
    } t_seq_beat;

    logic        i_clk;
    logic        i_rst_n              = 1'b0;
    logic        i_cfg_valid          = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data           = '0;
    logic        i_in_valid           = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd                = '0;
    logic [12:0] i_mem_address        = '0;
    logic [13:0] i_length             = '0;
    logic [4:0]  i_buffer_index       = '0;
    logic [7:0]  i_data_byte          = '0;
    logic        i_flag_start_sent    = 1'b0;
    logic        i_flag_address_done  = 1'b0;
    logic        i_flag_tx_empty      = 1'b0;
    logic        i_flag_rx_full       = 1'b0;
    logic        i_flag_byte_finished = 1'b0;
    logic        i_flag_ack_failure   = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall          = 1'b0;
    logic [2:0]  o_bus_action;
    logic [7:0]  o_tx_byte;
    logic        o_clear_ack_failure;
    logic        o_ack_disable;
    logic        o_stop;
    logic        o_rx_valid;
    logic [7:0]  o_rx_data;
    logic        o_rx_last;
    logic        o_done_res;
    logic [1:0]  o_status;

    // Our own copy of the sequencer state, advanced once per accepted input beat.
    t_phase      seq_phase      = PH_IDLE;
    logic [13:0] seq_index      = '0;
    logic [13:0] seq_count      = '0;
    logic [12:0] seq_target     = '0;
    logic [7:0]  page_copy [PAGE_BYTES];
    logic [6:0]  dev_addr_copy  = 7'd80;

    // Result beats predicted but not yet seen at the output, oldest first.
    t_result     bus_reply_q [$];
    int          mismatches      = 0;
    int          sent_beats      = 0;
    int          hang_count      = 0;
    // Set during the back-to-back stretch: neither side inserts bubbles then.
    logic        no_idle         = 1'b0;

    i2c_eeprom_transfer_sequencer #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_cmd                (i_cmd),
        .i_mem_address        (i_mem_address),
        .i_length             (i_length),
        .i_buffer_index       (i_buffer_index),
        .i_data_byte          (i_data_byte),
        .i_flag_start_sent    (i_flag_start_sent),
        .i_flag_address_done  (i_flag_address_done),
        .i_flag_tx_empty      (i_flag_tx_empty),
        .i_flag_rx_full       (i_flag_rx_full),
        .i_flag_byte_finished (i_flag_byte_finished),
        .i_flag_ack_failure   (i_flag_ack_failure),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_bus_action         (o_bus_action),
        .o_tx_byte            (o_tx_byte),
        .o_clear_ack_failure  (o_clear_ack_failure),
        .o_ack_disable        (o_ack_disable),
        .o_stop               (o_stop),
        .o_rx_valid           (o_rx_valid),
        .o_rx_data            (o_rx_data),
        .o_rx_last            (o_rx_last),
        .o_done_res           (o_done_res),
        .o_status             (o_status)
    );

    // 8 ns clock, starting low so that the first rising edge is a clean one.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Computes the result beat of one accepted input beat and advances the state copy.
    // Every input beat yields exactly one result beat, possibly all zero.
    function automatic t_result predict_bus_reply(input t_seq_beat beat);
        t_result    reply;
        logic [7:0] write_addr_byte;
        reply = '0;
        write_addr_byte = {dev_addr_copy, 1'b0};
        case (beat.cmd)
            CMD_START_READ, CMD_START_WRITE: begin
                if (seq_phase != PH_IDLE) begin
                    reply.status = ST_BUSY;
                end else if (int'(beat.mem_address) + int'(beat.length) > MEM_BYTES ||
                             (beat.cmd == CMD_START_WRITE && beat.length == '0)) begin
                    reply.status = ST_RANGE;
                end else begin
                    seq_target = beat.mem_address;
                    seq_count  = beat.length;
                    seq_index  = '0;
                    seq_phase  = (beat.cmd == CMD_START_READ) ? PH_R_START : PH_W_START;
                    reply.bus_action = ACT_START;
                end
            end
            CMD_LOAD_BYTE: begin
                page_copy[int'(beat.buffer_index) % PAGE_BYTES] = beat.data_byte;
            end
            default: begin
                case (seq_phase)
                    PH_R_START, PH_W_START: begin
                        if (beat.flags.start_sent) begin
                            reply.bus_action = ACT_WADDR;
                            reply.tx_byte    = write_addr_byte;
                            seq_phase = (seq_phase == PH_R_START) ? PH_R_WADDR : PH_W_WADDR;
                        end
                    end
                    PH_R_WADDR: begin
                        if (beat.flags.address_done) begin
                            reply.bus_action = ACT_BYTE;
                            reply.tx_byte    = {3'b000, seq_target[12:8]};
                            seq_phase = PH_R_ADDR_HI;
                        end
                    end
                    PH_R_ADDR_HI: begin
                        if (beat.flags.tx_empty) begin
                            reply.bus_action = ACT_BYTE;
                            reply.tx_byte    = seq_target[7:0];
                            seq_phase = PH_R_ADDR_LO;
                        end
                    end
                    PH_R_ADDR_LO: begin
                        if (beat.flags.tx_empty) begin
                            reply.bus_action = ACT_START;
                            seq_phase = PH_R_RESTART;
                        end
                    end
                    PH_R_RESTART: begin
                        if (beat.flags.start_sent) begin
                            reply.bus_action = ACT_RADDR;
                            reply.tx_byte    = write_addr_byte | 8'h01;
                            seq_phase = PH_R_RADDR;
                        end
                    end
                    PH_R_RADDR: begin
                        if (beat.flags.address_done) seq_phase = PH_R_DATA;
                    end
                    PH_R_DATA: begin
                        if (beat.flags.rx_full) begin
                            reply.rx_valid = 1'b1;
                            reply.rx_data  = beat.data_byte;
                            // A zero-length read ends on its first received byte.
                            if (int'(seq_index) + 1 >= int'(seq_count)) begin
                                reply.ack_disable = 1'b1;
                                reply.stop        = 1'b1;
                                reply.rx_last     = 1'b1;
                                reply.done_res    = 1'b1;
                                seq_phase = PH_IDLE;
                            end
                            seq_index = seq_index + 14'd1;
                        end
                    end
                    PH_W_WADDR: begin
                        // Acknowledge failure wins: the device is busy, poll it again.
                        if (beat.flags.ack_failure) begin
                            reply.clear_ack_failure = 1'b1;
                            reply.bus_action = ACT_START;
                            seq_phase = PH_W_START;
                        end else if (beat.flags.address_done) begin
                            reply.bus_action = ACT_BYTE;
                            reply.tx_byte    = {3'b000, seq_target[12:8]};
                            seq_phase = PH_W_ADDR_LO;
                        end
                    end
                    PH_W_ADDR_LO: begin
                        if (beat.flags.tx_empty) begin
                            reply.bus_action = ACT_BYTE;
                            reply.tx_byte    = seq_target[7:0];
                            seq_phase = PH_W_DATA;
                        end
                    end
                    PH_W_DATA: begin
                        if (beat.flags.tx_empty) begin
                            if (seq_index < seq_count) begin
                                // Page slots wrap for writes longer than the page.
                                reply.bus_action = ACT_BYTE;
                                reply.tx_byte    = page_copy[seq_index % PAGE_BYTES];
                                seq_index = seq_index + 14'd1;
                            end else begin
                                seq_phase = PH_W_LAST;
                            end
                        end
                    end
                    PH_W_LAST: begin
                        if (beat.flags.byte_finished) begin
                            reply.stop     = 1'b1;
                            reply.done_res = 1'b1;
                            seq_phase = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
        return reply;
    endfunction

    // A beat with every field random; callers overwrite what matters to them.
    // Each status flag is set one time in four, so most events carry few flags.
    function automatic t_seq_beat random_beat();
        t_seq_beat  beat;
        logic [5:0] flag_bits;
        for (int b = 0; b < 6; b++) flag_bits[b] = ($urandom_range(3) == 0);
        beat.cmd          = t_cmd'($urandom_range(3));
        beat.mem_address  = 13'($urandom_range(MEM_BYTES - 1));
        beat.length       = 14'($urandom_range(MEM_BYTES));
        beat.buffer_index = 5'($urandom_range(PAGE_BYTES - 1));
        beat.data_byte    = 8'($urandom_range(255));
        beat.flags        = flag_bits;
        return beat;
    endfunction

    // Offers one beat, with random bubbles ahead of it, and waits until it is taken.
    // Stall is sampled at the edge itself, so the beat counts when stall was low there.
    task automatic send_beat(input t_seq_beat beat);
        t_result reply;
        while (!no_idle && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_cmd                <= beat.cmd;
        i_mem_address        <= beat.mem_address;
        i_length             <= beat.length;
        i_buffer_index       <= beat.buffer_index;
        i_data_byte          <= beat.data_byte;
        i_flag_start_sent    <= beat.flags.start_sent;
        i_flag_address_done  <= beat.flags.address_done;
        i_flag_tx_empty      <= beat.flags.tx_empty;
        i_flag_rx_full       <= beat.flags.rx_full;
        i_flag_byte_finished <= beat.flags.byte_finished;
        i_flag_ack_failure   <= beat.flags.ack_failure;
        do @(posedge i_clk); while (o_in_stall);
        reply = predict_bus_reply(beat);
        bus_reply_q.push_back(reply);
        sent_beats++;
    endtask

    // Sends a status event. The flag the current phase waits for is forced to hit;
    // the ack failure flag is forced to poll, the others stay random noise.
    task automatic send_status_event(input logic hit, input logic poll);
        t_seq_beat beat;
        beat = random_beat();
        beat.cmd = CMD_BUS_EVENT;
        beat.flags.ack_failure = poll;
        case (seq_phase)
            PH_R_START, PH_R_RESTART, PH_W_START:   beat.flags.start_sent    = hit;
            PH_R_WADDR, PH_R_RADDR, PH_W_WADDR:     beat.flags.address_done  = hit;
            PH_R_ADDR_HI, PH_R_ADDR_LO,
            PH_W_ADDR_LO, PH_W_DATA:                beat.flags.tx_empty      = hit;
            PH_R_DATA:                              beat.flags.rx_full       = hit;
            PH_W_LAST:                              beat.flags.byte_finished = hit;
            default: ;
        endcase
        send_beat(beat);
    endtask

    task automatic send_start(input t_cmd cmd, input int mem, input int len);
        t_seq_beat beat;
        beat = random_beat();
        beat.cmd         = cmd;
        beat.mem_address = 13'(mem);
        beat.length      = 14'(len);
        send_beat(beat);
    endtask

    task automatic send_load(input int slot, input int value);
        t_seq_beat beat;
        beat = random_beat();
        beat.cmd          = CMD_LOAD_BYTE;
        beat.buffer_index = 5'(slot);
        beat.data_byte    = 8'(value);
        send_beat(beat);
    endtask

    // Lowers valid and waits until every predicted result has been seen.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (bus_reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The device address may only change with no transfer running.
    task automatic write_device_address(input logic [6:0] value);
        wait_for_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        dev_addr_copy = value;
    endtask

    // One well-formed transfer from start to stop, with noise events, loads and
    // rejected busy starts mixed in while it runs.
    task automatic run_transfer(input logic is_write, input int mem, input int len);
        int pick;
        send_start(is_write ? CMD_START_WRITE : CMD_START_READ, mem, len);
        while (seq_phase != PH_IDLE) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_load($urandom_range(PAGE_BYTES - 1), $urandom_range(255));
            end else if (pick < 9) begin
                send_start(t_cmd'($urandom_range(1)), $urandom_range(MEM_BYTES - 1),
                           $urandom_range(MEM_BYTES));
            end else begin
                send_status_event(pick >= 25, $urandom_range(99) < 12);
            end
        end
    endtask

    // Status events while idle are ignored, and starts beyond the memory end or
    // writes of zero bytes are refused with a range status.
    task automatic test_idle_and_range();
        t_seq_beat beat;
        beat = random_beat();
        beat.cmd   = CMD_BUS_EVENT;
        beat.flags = '1;
        send_beat(beat);
        send_start(CMD_START_READ, MEM_BYTES - 1, 2);
        send_start(CMD_START_WRITE, 0, 0);
        send_start(CMD_START_READ, 1, MEM_BYTES);
    endtask

    // A read of length zero at the last memory address: the address bytes hit their
    // extremes and the first received byte is the last. A missing flag and a start
    // during the transfer must both leave it undisturbed.
    task automatic test_zero_length_read();
        send_start(CMD_START_READ, MEM_BYTES - 1, 0);
        send_status_event(1'b0, 1'b0);
        send_start(CMD_START_WRITE, 0, 1);
        repeat (7) send_status_event(1'b1, 1'b0);
    endtask

    // Loads the first, second and last page slots with the bytes 00, FF and 5A hex.
    task automatic test_page_loads();
        send_load(0, 8'h00);
        send_load(1, 8'hFF);
        send_load(PAGE_BYTES - 1, 8'h5A);
    endtask

    // A two-byte write whose first address beat is refused by the device, so the
    // sequencer clears the failure and starts over before sending the data.
    task automatic test_write_ack_polling();
        send_start(CMD_START_WRITE, 13'h1F00, 2);
        send_status_event(1'b1, 1'b0);
        send_status_event(1'b1, 1'b1);
        repeat (7) send_status_event(1'b1, 1'b0);
    endtask

    // Fills the whole page so that any later write sends loaded slots only.
    task automatic test_page_fill();
        for (int slot = 0; slot < PAGE_BYTES; slot++) send_load(slot, $urandom_range(255));
    endtask

    // Mostly complete transfers with random content; the rest is refused starts,
    // loads and stray events while idle.
    task automatic test_random_traffic(input int n_beats);
        int        stop_at;
        int        pick;
        int        sel;
        int        len;
        int        mem;
        logic      is_write;
        t_seq_beat beat;
        stop_at = sent_beats + n_beats;
        while (sent_beats < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                is_write = 1'($urandom_range(1));
                sel = $urandom_range(99);
                if (sel < 60)      len = $urandom_range(1, 6);
                else if (sel < 88) len = $urandom_range(7, 40);
                else if (sel < 96) len = $urandom_range(41, 80);
                else               len = is_write ? 1 : 0;
                mem = ($urandom_range(9) == 0) ? MEM_BYTES - len
                                               : $urandom_range(MEM_BYTES - len);
                run_transfer(is_write, mem, len);
            end else if (pick < 86) begin
                beat = random_beat();
                beat.cmd = t_cmd'($urandom_range(1));
                if (beat.cmd == CMD_START_WRITE && $urandom_range(3) == 0) begin
                    beat.length = '0;
                end else begin
                    beat.mem_address = 13'($urandom_range(1, MEM_BYTES - 1));
                    beat.length = 14'($urandom_range(MEM_BYTES + 1 - int'(beat.mem_address),
                                                     MEM_BYTES));
                end
                send_beat(beat);
            end else if (pick < 95) begin
                send_load($urandom_range(PAGE_BYTES - 1), $urandom_range(255));
            end else begin
                beat = random_beat();
                beat.cmd = CMD_BUS_EVENT;
                send_beat(beat);
            end
        end
    endtask

    // Random traffic with no bubbles on either side.
    task automatic test_back_to_back(input int n_beats);
        no_idle = 1'b1;
        test_random_traffic(n_beats);
        no_idle = 1'b0;
    endtask

    // The receiving side stalls about one cycle in four, except back to back.
    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(99) < 27);
    end

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Every result beat taken at the output is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bus_reply_q.size() == 0) begin
                $error("result beat with nothing expected: bus_action %0d, status %0d",
                       o_bus_action, o_status);
                mismatches++;
            end else begin
                want = bus_reply_q.pop_front();
                compare_field("bus_action", 32'(want.bus_action), 32'(o_bus_action));
                compare_field("tx_byte", 32'(want.tx_byte), 32'(o_tx_byte));
                compare_field("clear_ack_failure", 32'(want.clear_ack_failure),
                              32'(o_clear_ack_failure));
                compare_field("ack_disable", 32'(want.ack_disable), 32'(o_ack_disable));
                compare_field("stop", 32'(want.stop), 32'(o_stop));
                compare_field("rx_valid", 32'(want.rx_valid), 32'(o_rx_valid));
                compare_field("rx_data", 32'(want.rx_data), 32'(o_rx_data));
                compare_field("rx_last", 32'(want.rx_last), 32'(o_rx_last));
                compare_field("done_res", 32'(want.done_res), 32'(o_done_res));
                compare_field("status", 32'(want.status), 32'(o_status));
            end
        end
    end

    // Hang detection: too many cycles in a row without any beat on any channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                hang_count <= 0;
            end else if (hang_count >= HANG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                hang_count <= hang_count + 1;
            end
        end
    end

    // Reset once, then the directed checks at the reset device address, then random
    // traffic under several device addresses including both extremes.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_and_range();
        test_zero_length_read();
        test_page_loads();
        test_write_ack_polling();
        write_device_address(7'd0);
        test_page_fill();
        test_random_traffic(400);
        write_device_address(7'd127);
        test_random_traffic(400);
        write_device_address(7'($urandom_range(127)));
        test_back_to_back(200);
        write_device_address(7'($urandom_range(127)));
        test_random_traffic(400);
        wait_for_drain();
        if (mismatches == 0 && bus_reply_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/i2c_seq_pkg.sv
sv/i2c_seq_ram.sv
sv/i2c_seq_step.sv
sv/i2c_eeprom_transfer_sequencer.sv
dv/tb_top.sv
